// File: hw/rtl/sms_pkg.sv
// Shared constants, types and helper functions for the stable merge sorter.
package sms_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int DATA_WIDTH = 32;
    localparam int PORT_WIDTH = 32;
    localparam int ADDR_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // which of the two memories an access goes to
    typedef enum logic {
        SEL_STORE   = 1'b0,
        SEL_SCRATCH = 1'b1
    } mem_sel_t;

    // merge engine command
    typedef struct packed {
        logic start;
        cnt_t count;
    } mrg_ctrl_t;

    // merge engine status
    typedef struct packed {
        logic     busy;
        logic     done;
        mem_sel_t res_sel;
    } mrg_stat_t;

    // merge engine memory access, one read and one write per cycle
    typedef struct packed {
        logic     rd_en;
        mem_sel_t rd_sel;
        addr_t    rd_addr;
        logic     wr_en;
        mem_sel_t wr_sel;
        addr_t    wr_addr;
        data_t    wr_data;
    } mem_req_t;

    // port value to stored value: low bits taken, sign extended when wider
    function automatic data_t to_data(input logic [PORT_WIDTH-1:0] v);
        logic signed [63:0] w;
        w = 64'($signed(v));
        return w[DATA_WIDTH-1:0];
    endfunction

    // stored value to port value, sign extended
    function automatic logic [PORT_WIDTH-1:0] to_port(input data_t d);
        logic signed [63:0] w;
        w = 64'($signed(d));
        return w[PORT_WIDTH-1:0];
    endfunction

endpackage

// File: hw/rtl/sms_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module sms_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/sms_merger.sv
// Bottom-up merge engine: merges runs pass by pass between the two memories.
module sms_merger (
    input  logic              clk,
    input  logic              rst_n,
    input  sms_pkg::mrg_ctrl_t ctrl,
    input  sms_pkg::data_t    store_data,
    input  sms_pkg::data_t    scratch_data,
    output sms_pkg::mrg_stat_t stat,
    output sms_pkg::mem_req_t req
);
    import sms_pkg::*;

    localparam int SPAN_W = CNT_W + 2;
    typedef logic [SPAN_W-1:0] span_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_PASS,
        M_RUN,
        M_LOAD_A,
        M_LOAD_B,
        M_MERGE,
        M_FETCH
    } mstate_t;

    mstate_t  state_reg, state_next;
    mem_sel_t src_sel_reg, src_sel_next;
    cnt_t     n_reg, n_next;
    span_t    width_reg, width_next;
    cnt_t     lo_reg, lo_next;
    cnt_t     mid_reg, mid_next;
    cnt_t     hi_reg, hi_next;
    cnt_t     a_reg, a_next;
    cnt_t     b_reg, b_next;
    cnt_t     k_reg, k_next;
    data_t    head_a_reg, head_a_next;
    data_t    head_b_reg, head_b_next;
    logic     took_a_reg, took_a_next;

    data_t rd_data;
    span_t lo_w;
    span_t lo_2w;
    span_t n_span;
    logic  take_a;
    cnt_t  a_inc;
    cnt_t  b_inc;
    cnt_t  k_inc;

    // read data of the current source memory
    assign rd_data = (src_sel_reg == SEL_SCRATCH) ? scratch_data : store_data;

    assign n_span = span_t'(n_reg);
    assign lo_w   = span_t'(lo_reg) + width_reg;
    assign lo_2w  = lo_w + width_reg;
    assign a_inc  = a_reg + cnt_t'(1);
    assign b_inc  = b_reg + cnt_t'(1);
    assign k_inc  = k_reg + cnt_t'(1);

    // left run wins on ties, which keeps the sort stable
    assign take_a = (a_reg < mid_reg) &&
                    ((b_reg >= hi_reg) || ($signed(head_a_reg) <= $signed(head_b_reg)));

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        src_sel_next = src_sel_reg;
        n_next       = n_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        head_a_next  = head_a_reg;
        head_b_next  = head_b_reg;
        took_a_next  = took_a_reg;

        req          = '0;
        req.rd_sel   = src_sel_reg;
        req.wr_sel   = mem_sel_t'(~src_sel_reg);
        stat.busy    = (state_reg != M_IDLE);
        stat.done    = 1'b0;
        stat.res_sel = src_sel_reg;

        case (state_reg)
            M_IDLE:
            begin
                if (ctrl.start)
                begin
                    n_next       = ctrl.count;
                    width_next   = span_t'(1);
                    src_sel_next = SEL_STORE;
                    state_next   = M_PASS;
                end
            end
            M_PASS:
            begin
                if (width_reg >= n_span)
                begin
                    stat.done  = 1'b1;
                    state_next = M_IDLE;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = M_RUN;
                end
            end
            M_RUN:
            begin
                mid_next    = (lo_w > n_span) ? n_reg : lo_w[CNT_W-1:0];
                hi_next     = (lo_2w > n_span) ? n_reg : lo_2w[CNT_W-1:0];
                a_next      = lo_reg;
                b_next      = (lo_w > n_span) ? n_reg : lo_w[CNT_W-1:0];
                k_next      = lo_reg;
                req.rd_en   = 1'b1;
                req.rd_addr = lo_reg[ADDR_W-1:0];
                state_next  = M_LOAD_A;
            end
            M_LOAD_A:
            begin
                head_a_next = rd_data;
                if (b_reg < hi_reg)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = b_reg[ADDR_W-1:0];
                end
                state_next = M_LOAD_B;
            end
            M_LOAD_B:
            begin
                // value unused when the right run is empty
                head_b_next = rd_data;
                state_next  = M_MERGE;
            end
            M_MERGE:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = k_reg[ADDR_W-1:0];
                req.wr_data = take_a ? head_a_reg : head_b_reg;
                k_next      = k_inc;
                took_a_next = take_a;
                if (take_a)
                begin
                    a_next = a_inc;
                    if (a_inc < mid_reg)
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = a_inc[ADDR_W-1:0];
                    end
                end
                else
                begin
                    b_next = b_inc;
                    if (b_inc < hi_reg)
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = b_inc[ADDR_W-1:0];
                    end
                end
                if (k_inc == hi_reg)
                begin
                    if (lo_2w >= n_span)
                    begin
                        src_sel_next = mem_sel_t'(~src_sel_reg);
                        width_next   = width_reg + width_reg;
                        state_next   = M_PASS;
                    end
                    else
                    begin
                        lo_next    = lo_2w[CNT_W-1:0];
                        state_next = M_RUN;
                    end
                end
                else
                begin
                    state_next = M_FETCH;
                end
            end
            M_FETCH:
            begin
                if (took_a_reg)
                begin
                    head_a_next = rd_data;
                end
                else
                begin
                    head_b_next = rd_data;
                end
                state_next = M_MERGE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= M_IDLE;
            src_sel_reg <= SEL_STORE;
            n_reg       <= '0;
            width_reg   <= '0;
            lo_reg      <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            k_reg       <= '0;
            took_a_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            src_sel_reg <= src_sel_next;
            n_reg       <= n_next;
            width_reg   <= width_next;
            lo_reg      <= lo_next;
            mid_reg     <= mid_next;
            hi_reg      <= hi_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            k_reg       <= k_next;
            took_a_reg  <= took_a_next;
        end
    end

    // run heads
    always_ff @(posedge clk)
    begin
        head_a_reg <= head_a_next;
        head_b_reg <= head_b_next;
    end

`ifndef SYNTHESIS
    // output slot tracks the two run pointers
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == M_MERGE) |->
            (span_t'(k_reg) + span_t'(mid_reg) == span_t'(a_reg) + span_t'(b_reg)))
        else $error("merge output index out of step with run pointers");

    // something is left to merge whenever a write is due
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == M_MERGE) |-> ((a_reg < mid_reg || b_reg < hi_reg) && k_reg < hi_reg))
        else $error("merge step with both runs exhausted");

    // a finished sort goes back to idle and does not restart on its own
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> (state_reg == M_IDLE) && !req.wr_en)
        else $error("merge engine kept running after done");
`endif

endmodule

// File: hw/rtl/stable_merge_sort.sv
// Stable merge sorter top level: item loading, sort control and result emission.
//
// Loads signed values one per cycle until an item flagged last_item (up to
// MAX_ITEMS; later items are dropped and flagged on every result), then sorts
// them with a stable bottom-up merge between two single-port-pair RAMs and
// streams the sorted set out, marking the final value with last_out. Input is
// stalled from the last_item until the final result is taken. Each merge pass
// steps through its run pairs, loading both run heads for each pair and then
// writing one value per MERGE step with a FETCH between, because every merged
// value waits for one read of the source RAM; emission reads, captures and
// hands over each value in turn.
module stable_merge_sort (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sorted_value,
    output logic        last_out,
    output logic        overflowed
);
    import sms_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_SORT,
        S_EMIT_RD,
        S_EMIT_CAP,
        S_EMIT_WAIT
    } tstate_t;

    tstate_t  state_reg, state_next;
    cnt_t     count_reg, count_next;
    logic     ovf_reg, ovf_next;
    mem_sel_t res_sel_reg, res_sel_next;
    cnt_t     idx_reg, idx_next;
    logic     out_valid_reg, out_valid_next;
    logic [PORT_WIDTH-1:0] sorted_value_reg, sorted_value_next;
    logic     last_out_reg, last_out_next;

    mrg_ctrl_t mctrl;
    mrg_stat_t mstat;
    mem_req_t  mreq;

    logic  in_acc;
    logic  out_acc;
    logic  store_fit;
    logic  em_rd;
    cnt_t  em_idx;
    data_t store_rd, scratch_rd, res_data;

    logic  st_wr_en, sc_wr_en, st_rd_en, sc_rd_en;
    addr_t st_wr_addr, st_rd_addr, sc_rd_addr;
    data_t st_wr_data;

    assign in_stall  = (state_reg != S_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign store_fit = (count_reg < cnt_t'(MAX_ITEMS));

    assign mctrl.start = (state_reg == S_START);
    assign mctrl.count = count_reg;

    assign res_data = (res_sel_reg == SEL_SCRATCH) ? scratch_rd : store_rd;

    // memory port steering: loader, merge engine, emitter
    always_comb
    begin
        if (in_acc && store_fit)
        begin
            st_wr_en   = 1'b1;
            st_wr_addr = count_reg[ADDR_W-1:0];
            st_wr_data = to_data(value);
        end
        else
        begin
            st_wr_en   = mreq.wr_en && (mreq.wr_sel == SEL_STORE);
            st_wr_addr = mreq.wr_addr;
            st_wr_data = mreq.wr_data;
        end
        sc_wr_en = mreq.wr_en && (mreq.wr_sel == SEL_SCRATCH);

        if (em_rd)
        begin
            st_rd_en   = (res_sel_reg == SEL_STORE);
            sc_rd_en   = (res_sel_reg == SEL_SCRATCH);
            st_rd_addr = em_idx[ADDR_W-1:0];
            sc_rd_addr = em_idx[ADDR_W-1:0];
        end
        else
        begin
            st_rd_en   = mreq.rd_en && (mreq.rd_sel == SEL_STORE);
            sc_rd_en   = mreq.rd_en && (mreq.rd_sel == SEL_SCRATCH);
            st_rd_addr = mreq.rd_addr;
            sc_rd_addr = mreq.rd_addr;
        end
    end

    // load, sort and emit control
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        res_sel_next      = res_sel_reg;
        idx_next          = idx_reg;
        out_valid_next    = out_valid_reg;
        sorted_value_next = sorted_value_reg;
        last_out_next     = last_out_reg;
        em_rd             = 1'b0;
        em_idx            = idx_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (store_fit)
                    begin
                        count_next = count_reg + cnt_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                state_next = S_SORT;
            end
            S_SORT:
            begin
                if (mstat.done)
                begin
                    res_sel_next = mstat.res_sel;
                    idx_next     = '0;
                    state_next   = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                em_rd      = 1'b1;
                state_next = S_EMIT_CAP;
            end
            S_EMIT_CAP:
            begin
                sorted_value_next = to_port(res_data);
                last_out_next     = (idx_reg + cnt_t'(1) == count_reg);
                out_valid_next    = 1'b1;
                state_next        = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (last_out_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        // fetch the next value while this one is handed over
                        idx_next   = idx_reg + cnt_t'(1);
                        em_rd      = 1'b1;
                        em_idx     = idx_reg + cnt_t'(1);
                        state_next = S_EMIT_CAP;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_sel_reg   <= SEL_STORE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            res_sel_reg   <= res_sel_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            last_out_reg  <= last_out_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        sorted_value_reg <= sorted_value_next;
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign last_out     = last_out_reg;
    assign overflowed   = ovf_reg;

    sms_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (DATA_WIDTH)
    ) u_item_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (store_rd)
    );

    sms_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (DATA_WIDTH)
    ) u_merge_scratch (
        .clk     (clk),
        .wr_en   (sc_wr_en),
        .wr_addr (mreq.wr_addr),
        .wr_data (mreq.wr_data),
        .rd_en   (sc_rd_en),
        .rd_addr (sc_rd_addr),
        .rd_data (scratch_rd)
    );

    sms_merger u_merger (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (mctrl),
        .store_data   (store_rd),
        .scratch_data (scratch_rd),
        .stat         (mstat),
        .req          (mreq)
    );

`ifndef SYNTHESIS
    // no new item is taken while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while a result is pending");

    // stored count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(MAX_ITEMS))
        else $error("item count beyond capacity");

    // taking the final result reopens the input with an empty set
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_out) |=>
            (!out_valid && !in_stall && count_reg == '0 && !overflowed))
        else $error("set not closed after final result");

    // the merge engine only runs while the top level waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mstat.busy |-> (state_reg == S_SORT))
        else $error("merge engine active outside the sort phase");
`endif

endmodule

// File: test/tb_stable_merge_sort.sv
// stable_merge_sort test: directed+random sets, stalls on both sides, scoreboard checks
module tb_stable_merge_sort;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 148;

    typedef logic signed [sms_pkg::DATA_WIDTH-1:0] sval_t;

    // Sorted-set predictor and store of expected sorted values
    class sort_scoreboard;
        typedef struct {
            logic [31:0] sorted_value;
            logic        last_out;
            logic        overflowed;
        } sorted_rec_t;

        sval_t       held[$];
        bit          dropped;
        sorted_rec_t expected_q[$];
        int          errors;

        // record an accepted item; on last_item sort the set and queue the results
        function void note_input(input logic [31:0] v, input logic last);
            sval_t       src[$];
            sval_t       dst[$];
            sval_t       tmp[$];
            sorted_rec_t rec;
            logic signed [31:0] wide;
            int n, width, lo, mid, hi, a, b;
            if (held.size() < sms_pkg::MAX_ITEMS)
                held.push_back(v[sms_pkg::DATA_WIDTH-1:0]);
            else
                dropped = 1'b1;
            if (!last)
                return;
            n   = held.size();
            src = held;
            dst = held;
            // bottom-up merge, left run wins on ties
            for (width = 1; width < n; width *= 2)
            begin
                for (lo = 0; lo < n; lo += 2 * width)
                begin
                    mid = (lo + width > n) ? n : lo + width;
                    hi  = (lo + 2 * width > n) ? n : lo + 2 * width;
                    a   = lo;
                    b   = mid;
                    for (int k = lo; k < hi; k++)
                    begin
                        if (a < mid && (b >= hi || src[a] <= src[b]))
                        begin
                            dst[k] = src[a];
                            a++;
                        end
                        else
                        begin
                            dst[k] = src[b];
                            b++;
                        end
                    end
                end
                tmp = src;
                src = dst;
                dst = tmp;
            end
            for (int k = 0; k < n; k++)
            begin
                wide             = src[k];
                rec.sorted_value = wide;
                rec.last_out     = (k == n - 1);
                rec.overflowed   = dropped;
                expected_q.push_back(rec);
            end
            held.delete();
            dropped = 1'b0;
        endfunction

        // compare one accepted result with the oldest expected one
        function void check_result(input logic [31:0] sv, input logic lo, input logic ov);
            sorted_rec_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: sorted_value %0d", $signed(sv));
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (sv !== want.sorted_value)
            begin
                $error("sorted_value: expected %0d, got %0d",
                       $signed(want.sorted_value), $signed(sv));
                errors++;
            end
            if (lo !== want.last_out)
            begin
                $error("last_out: expected %0b, got %0b", want.last_out, lo);
                errors++;
            end
            if (ov !== want.overflowed)
            begin
                $error("overflowed: expected %0b, got %0b", want.overflowed, ov);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] value;
    logic        last_item;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] sorted_value;
    logic        last_out;
    logic        overflowed;

    sort_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int sent_items;
    int idle_cycles;

    stable_merge_sort u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflowed   (overflowed)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // value mix: extremes, a narrow band for ties, full random
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return 32'($urandom_range(8)) - 32'd4;
            default: return $urandom;
        endcase
    endfunction

    // offer one item, hold it until accepted
    task automatic send_item(input logic [31:0] v, input logic last);
        // idling profile follows progress through the run
        if (sent_items < 70)
        begin
            send_idle_pct = 9;
            stall_pct     = 51;
        end
        else if (sent_items < 140)
        begin
            send_idle_pct = 51;
            stall_pct     = 9;
        end
        else
        begin
            send_idle_pct = 0;
            stall_pct     = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        value     <= v;
        last_item <= last;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(v, last);
        sent_items++;
    endtask

    // result side: random stall, check on every accepted item
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(sorted_value, last_out, overflowed);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog: too long without any accepted item on either channel
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [31:0] dir_vals [22];
        bit          dir_last [22];
        int set_no;
        int set_size;
        int rand_items;

        sb            = new;
        send_idle_pct = 9;
        stall_pct     = 51;
        sent_items    = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        value        <= '0;
        last_item    <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single item, extremes, ties, descending, ascending, pair
        dir_vals = '{32'd5,
                     32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'hffff_ffff,
                     32'd3, 32'd3, 32'd3,
                     32'd4, 32'd3, 32'd2, 32'd1, 32'd0, 32'hffff_ffff, 32'hffff_fffe,
                     32'hffff_fffd, 32'hffff_fffe, 32'hffff_ffff, 32'd0, 32'd1,
                     32'd1, 32'hffff_ffff};
        dir_last = '{1'b1,
                     1'b0, 1'b0, 1'b0, 1'b1,
                     1'b0, 1'b0, 1'b1,
                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                     1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                     1'b0, 1'b1};
        for (int i = 0; i < 22; i++)
            send_item(dir_vals[i], dir_last[i]);

        // random sets: mostly small, one over capacity, one exactly full
        set_no     = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (set_no == 2)
                set_size = sms_pkg::MAX_ITEMS + 3;
            else if (set_no == 6)
                set_size = sms_pkg::MAX_ITEMS;
            else
                set_size = $urandom_range(12, 1);
            for (int i = 0; i < set_size; i++)
                send_item(pick_value(), i == set_size - 1);
            rand_items += set_size;
            set_no++;
        end
        in_valid <= 1'b0;

        // drain, then watch for stray results
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/sms_pkg.sv
hw/rtl/sms_ram.sv
hw/rtl/sms_merger.sv
hw/rtl/stable_merge_sort.sv
test/tb_stable_merge_sort.sv
